>>> rtl/request_bucket_arranger_macros.svh
// Assertion macros for the request bucket arranger.
`ifndef REQUEST_BUCKET_ARRANGER_MACROS_SVH
`define REQUEST_BUCKET_ARRANGER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("request_bucket_arranger: assertion failed");
`define RBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("request_bucket_arranger: assertion failed");
`define RBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("request_bucket_arranger: assertion failed");
`else
`define RBA_ASSERT(lbl, clk, rst_n, prop)
`define RBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/rba_pkg.sv
package rba_pkg;

  localparam int unsigned NUM_BUCKETS      = 16;
  localparam int unsigned BKT_W            = 4;
  localparam int unsigned SPLIT_W          = 3;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned ITEM_W           = 16;
  localparam int unsigned QTOK_W           = 16;
  localparam int unsigned KVTOK_W          = 20;
  localparam int unsigned THRESH_W         = 20;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd4096;
  localparam int unsigned BUCKET_DEPTH_DEF = 64;
  localparam int unsigned HANDLE_BITS_DEF  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CHECKED = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [BKT_W-1:0]  bucket;
    logic              list_start;
    logic [ITEM_W-1:0] handle;
  } op_t;

  typedef struct packed {
    logic               data_valid;
    logic [SPLIT_W-1:0] split_index;
    logic               last_in_split;
    logic               last_overall;
    logic               order_error;
    logic               overflow;
    logic               empty_res;
  } res_t;

endpackage

>>> rtl/rba_ram.sv
module rba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rba_front.sv
module rba_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rba_pkg::THRESH_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rba_pkg::CMD_W-1:0]     cmd_i,
  input  logic [rba_pkg::ITEM_W-1:0]    item_handle_i,
  input  logic [rba_pkg::QTOK_W-1:0]    query_tokens_i,
  input  logic [rba_pkg::KVTOK_W-1:0]   kv_tokens_i,
  input  logic                          save_kv_i,
  input  logic                          kvp_request_i,
  input  logic                          list_start_i,
  output logic                          op_valid_o,
  input  logic                          op_ready_i,
  output rba_pkg::op_t                  op_o
);
  import rba_pkg::*;

  logic [THRESH_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // each true test sorts later
  always_comb begin
    op_o.cmd        = cmd_e'(cmd_i);
    op_o.bucket[3]  = query_tokens_i <= QTOK_W'(1);
    op_o.bucket[2]  = kv_tokens_i <= thresh_q;
    op_o.bucket[1]  = !save_kv_i;
    op_o.bucket[0]  = kvp_request_i;
    op_o.list_start = list_start_i;
    op_o.handle     = item_handle_i;
  end

  assign op_valid_o = in_valid_i;
  assign in_ready_o = op_ready_i;

endmodule

>>> rtl/rba_queue.sv
module rba_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  rba_pkg::op_t op_i,
  output logic         valid_o,
  input  logic         ready_i,
  output rba_pkg::op_t op_o
);
  import rba_pkg::*;

  localparam int unsigned QD    = 2;
  localparam int unsigned PTR_W = $clog2(QD);
  localparam int unsigned CNT_W = $clog2(QD + 1);

  op_t              slot_q [QD];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign ready_o = cnt_q != CNT_W'(QD);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign op_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> rtl/rba_back.sv
`include "request_bucket_arranger_macros.svh"

module rba_back #(
  parameter int unsigned BUCKET_DEPTH = rba_pkg::BUCKET_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS  = rba_pkg::HANDLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  output logic                       op_ready_o,
  input  rba_pkg::op_t               op_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rba_pkg::res_t              res_o,
  output logic [rba_pkg::ITEM_W-1:0] handle_o
);
  import rba_pkg::*;

  localparam int unsigned OFF_W    = BUCKET_DEPTH > 1 ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned ADDR_W   = $clog2(MEM_DEPTH);

  back_state_e       state_q, state_d;
  logic [FILL_W-1:0] fill_q [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_d [NUM_BUCKETS];
  logic [BKT_W-1:0]  rd_bkt_q, rd_bkt_d;
  logic [OFF_W-1:0]  rd_off_q, rd_off_d;
  logic [BKT_W-1:0]  prev_q, prev_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic [ITEM_W-1:0] handle_q, handle_d;

  logic                   pop;
  logic [NUM_BUCKETS-1:0] nonempty, hit_cur, pick, later;
  logic                   use_cur, found, more_here, last_split, last_all;
  logic [BKT_W-1:0]       fb, tb, ref_bkt;
  logic [OFF_W-1:0]       foff;
  logic [FILL_W-1:0]      off_nxt;
  logic                   full;

  logic                   we, re;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [HANDLE_BITS-1:0] wdata, rdata;
  logic [31:0]            rdata_wide;

  // search for the next stored entry from the cursor, wrapping to the start
  always_comb begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      nonempty[b] = fill_q[b] != '0;
      if (BKT_W'(b) > rd_bkt_q) begin
        hit_cur[b] = nonempty[b];
      end else if (BKT_W'(b) == rd_bkt_q) begin
        hit_cur[b] = FILL_W'(rd_off_q) < fill_q[b];
      end else begin
        hit_cur[b] = 1'b0;
      end
    end
    use_cur = |hit_cur;
    pick    = use_cur ? hit_cur : nonempty;
    found   = |pick;
    fb      = '0;
    for (int b = NUM_BUCKETS - 1; b >= 0; b--) begin
      if (pick[b]) begin
        fb = BKT_W'(b);
      end
    end
    foff = (use_cur && fb == rd_bkt_q) ? rd_off_q : '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      later[b] = nonempty[b] && (BKT_W'(b) > fb);
    end
    off_nxt    = FILL_W'(foff) + FILL_W'(1);
    more_here  = off_nxt < fill_q[fb];
    last_split = !more_here && (fb[0] || fill_q[{fb[BKT_W-1:1], 1'b1}] == '0);
    last_all   = !more_here && !(|later);
  end

  assign tb      = op_i.bucket;
  assign full    = fill_q[tb] == FILL_W'(BUCKET_DEPTH);
  assign ref_bkt = op_i.list_start ? '0 : prev_q;

  assign waddr = ADDR_W'(tb) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(fill_q[tb][OFF_W-1:0]);
  assign raddr = ADDR_W'(fb) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(foff);
  assign wdata = HANDLE_BITS'(32'(op_i.handle));
  assign rdata_wide = 32'(rdata);

  assign op_ready_o = (state_q == BK_IDLE) && (!out_valid_q || out_ready_i);
  assign pop        = op_valid_i && op_ready_o;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_bkt_d    = rd_bkt_q;
    rd_off_d    = rd_off_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    handle_d    = handle_q;
    we          = 1'b0;
    re          = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          res_d    = '0;
          handle_d = '0;
          case (op_i.cmd)
            CMD_APPEND: begin
              out_valid_d = 1'b1;
              if (full) begin
                res_d.overflow = 1'b1;
              end else begin
                we         = 1'b1;
                fill_d[tb] = fill_q[tb] + FILL_W'(1);
              end
            end
            CMD_CHECKED: begin
              out_valid_d = 1'b1;
              if (tb < ref_bkt) begin
                res_d.order_error = 1'b1;
              end else begin
                prev_d = tb;
                if (full) begin
                  res_d.overflow = 1'b1;
                end else begin
                  we         = 1'b1;
                  fill_d[tb] = fill_q[tb] + FILL_W'(1);
                end
              end
            end
            CMD_READ: begin
              if (!found) begin
                out_valid_d     = 1'b1;
                res_d.empty_res = 1'b1;
              end else begin
                re                  = 1'b1;
                state_d             = BK_READ;
                res_d.data_valid    = 1'b1;
                res_d.split_index   = fb[BKT_W-1:1];
                res_d.last_in_split = last_split;
                res_d.last_overall  = last_all;
                if (last_all) begin
                  rd_bkt_d = '0;
                  rd_off_d = '0;
                end else if (more_here) begin
                  rd_bkt_d = fb;
                  rd_off_d = off_nxt[OFF_W-1:0];
                end else begin
                  rd_bkt_d = fb + BKT_W'(1);
                  rd_off_d = '0;
                end
              end
            end
            CMD_CLEAR: begin
              out_valid_d = 1'b1;
              for (int b = 0; b < NUM_BUCKETS; b++) begin
                fill_d[b] = '0;
              end
              rd_bkt_d = '0;
              rd_off_d = '0;
              prev_d   = '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        out_valid_d = 1'b1;
        handle_d    = rdata_wide[ITEM_W-1:0];
        state_d     = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_bkt_q    <= '0;
      rd_off_q    <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rd_bkt_q    <= rd_bkt_d;
      rd_off_q    <= rd_off_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    handle_q <= handle_d;
  end

  rba_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign handle_o    = handle_q;

  `RBA_ASSERT_NEXT(a_read_lands, clk_i, rst_ni, state_q == BK_READ, out_valid_q)
  `RBA_ASSERT_IMPL(a_read_slot_free, clk_i, rst_ni, state_q == BK_READ, !out_valid_q)
  `RBA_ASSERT_IMPL(a_cursor_in_fill, clk_i, rst_ni, rd_off_q != '0,
                   FILL_W'(rd_off_q) < fill_q[rd_bkt_q])
  `RBA_ASSERT(a_one_flag, clk_i, rst_ni, !out_valid_q || $onehot0({res_q.data_valid,
              res_q.order_error, res_q.overflow, res_q.empty_res}))

endmodule

>>> rtl/request_bucket_arranger.sv
// Append, checked append, clear and a read of an empty arranger pass the queue slot and the
// output register; a handle read also passes the registered handle store read and the read state.
// Throughput: one command per cycle unless the output stalls or a handle read is in progress.
// A 2-entry queue parts the classifier from the executing back end.
// Reset: fill counts, read cursor, previous bucket and handshakes cleared, threshold set to 4096;
// the handle store is not cleared and needs no clearing pass.
module request_bucket_arranger #(
  parameter int unsigned BUCKET_DEPTH = rba_pkg::BUCKET_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS  = rba_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rba_pkg::THRESH_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rba_pkg::CMD_W-1:0]     cmd_i,
  input  logic [rba_pkg::ITEM_W-1:0]    item_handle_i,
  input  logic [rba_pkg::QTOK_W-1:0]    query_tokens_i,
  input  logic [rba_pkg::KVTOK_W-1:0]   kv_tokens_i,
  input  logic                          save_kv_i,
  input  logic                          kvp_request_i,
  input  logic                          list_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          data_valid_o,
  output logic [rba_pkg::ITEM_W-1:0]    out_handle_o,
  output logic [rba_pkg::SPLIT_W-1:0]   split_index_o,
  output logic                          last_in_split_o,
  output logic                          last_overall_o,
  output logic                          order_error_o,
  output logic                          overflow_o,
  output logic                          empty_res_o
);
  import rba_pkg::*;

  op_t  fr_op, q_op;
  logic fr_valid, fr_ready, q_valid, q_ready;
  res_t res;

  rba_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .item_handle_i  (item_handle_i),
    .query_tokens_i (query_tokens_i),
    .kv_tokens_i    (kv_tokens_i),
    .save_kv_i      (save_kv_i),
    .kvp_request_i  (kvp_request_i),
    .list_start_i   (list_start_i),
    .op_valid_o     (fr_valid),
    .op_ready_i     (fr_ready),
    .op_o           (fr_op)
  );

  rba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .op_i    (fr_op),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .op_o    (q_op)
  );

  rba_back #(
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .op_i        (q_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .handle_o    (out_handle_o)
  );

  assign data_valid_o    = res.data_valid;
  assign split_index_o   = res.split_index;
  assign last_in_split_o = res.last_in_split;
  assign last_overall_o  = res.last_overall;
  assign order_error_o   = res.order_error;
  assign overflow_o      = res.overflow;
  assign empty_res_o     = res.empty_res;

endmodule

>>> sim/request_bucket_arranger_tb.sv
module request_bucket_arranger_tb;
  import rba_pkg::*;

  localparam int unsigned DEPTH       = BUCKET_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 50;

  typedef struct packed {
    logic               data_valid;
    logic [ITEM_W-1:0]  handle;
    logic [SPLIT_W-1:0] split;
    logic               last_split;
    logic               last_all;
    logic               order_err;
    logic               ovf;
    logic               empty;
  } reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [THRESH_W-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [ITEM_W-1:0]   item_handle_i;
  logic [QTOK_W-1:0]   query_tokens_i;
  logic [KVTOK_W-1:0]  kv_tokens_i;
  logic                save_kv_i;
  logic                kvp_request_i;
  logic                list_start_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                data_valid_o;
  logic [ITEM_W-1:0]   out_handle_o;
  logic [SPLIT_W-1:0]  split_index_o;
  logic                last_in_split_o;
  logic                last_overall_o;
  logic                order_error_o;
  logic                overflow_o;
  logic                empty_res_o;

  // predicted arranger state
  logic [ITEM_W-1:0]   store_m [NUM_BUCKETS][DEPTH];
  int unsigned         fill_m [NUM_BUCKETS] = '{default: 0};
  int unsigned         cur_bkt = 0;
  int unsigned         cur_off = 0;
  int unsigned         prev_bkt = 0;
  logic [THRESH_W-1:0] thresh_m = THRESH_RESET;

  reply_t      arranged_replies [$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;

  request_bucket_arranger u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .item_handle_i  (item_handle_i),
    .query_tokens_i (query_tokens_i),
    .kv_tokens_i    (kv_tokens_i),
    .save_kv_i      (save_kv_i),
    .kvp_request_i  (kvp_request_i),
    .list_start_i   (list_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_valid_o   (data_valid_o),
    .out_handle_o   (out_handle_o),
    .split_index_o  (split_index_o),
    .last_in_split_o(last_in_split_o),
    .last_overall_o (last_overall_o),
    .order_error_o  (order_error_o),
    .overflow_o     (overflow_o),
    .empty_res_o    (empty_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch, cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp));
    end
  endtask

  function automatic logic [BKT_W-1:0] bucket_of(input logic [QTOK_W-1:0] q,
                                                 input logic [KVTOK_W-1:0] kv,
                                                 input logic sv, input logic kvp);
    return {q <= QTOK_W'(1), kv <= thresh_m, !sv, kvp};
  endfunction

  function automatic bit stow(input int unsigned b, input logic [ITEM_W-1:0] h);
    if (fill_m[b] >= DEPTH) return 1'b0;
    store_m[b][fill_m[b]] = h;
    fill_m[b]++;
    return 1'b1;
  endfunction

  // first stored entry at or after (b0, off0)
  function automatic bit next_entry(input int unsigned b0, input int unsigned off0,
                                    output int unsigned fb, output int unsigned fo);
    int unsigned off;
    fb = 0;
    fo = 0;
    for (int unsigned b = b0; b < NUM_BUCKETS; b++) begin
      off = (b == b0) ? off0 : 0;
      if (off < fill_m[b]) begin
        fb = b;
        fo = off;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic arrange_step(input cmd_e c, input logic [ITEM_W-1:0] h,
                              input logic [QTOK_W-1:0] q, input logic [KVTOK_W-1:0] kv,
                              input logic sv, input logic kvp, input logic ls,
                              output reply_t r);
    int unsigned b, floor_b, fb, fo, nb, no;
    bit found, more_here, last_all;
    r = '0;
    b = 32'(bucket_of(q, kv, sv, kvp));
    case (c)
      CMD_APPEND: begin
        r.ovf = !stow(b, h);
      end
      CMD_CHECKED: begin
        floor_b = ls ? 0 : prev_bkt;
        if (b < floor_b) begin
          r.order_err = 1'b1;
        end else begin
          r.ovf = !stow(b, h);
          prev_bkt = b;
        end
      end
      CMD_READ: begin
        found = next_entry(cur_bkt, cur_off, fb, fo);
        if (!found) found = next_entry(0, 0, fb, fo);
        if (!found) begin
          r.empty = 1'b1;
        end else begin
          more_here    = (fo + 1) < fill_m[fb];
          last_all     = !next_entry(fb, fo + 1, nb, no);
          r.data_valid = 1'b1;
          r.handle     = store_m[fb][fo];
          r.split      = SPLIT_W'(fb >> 1);
          r.last_split = !more_here && ((fb % 2 == 1) || fill_m[fb + 1] == 0);
          r.last_all   = last_all;
          if (last_all) begin
            cur_bkt = 0;
            cur_off = 0;
          end else if (more_here) begin
            cur_bkt = fb;
            cur_off = fo + 1;
          end else begin
            cur_bkt = fb + 1;
            cur_off = 0;
          end
        end
      end
      default: begin
        fill_m   = '{default: 0};
        cur_bkt  = 0;
        cur_off  = 0;
        prev_bkt = 0;
      end
    endcase
  endtask

  // valid stays high across back-to-back transfers; lowered only for a gap
  task automatic send_request(input cmd_e c, input logic [ITEM_W-1:0] h,
                              input logic [QTOK_W-1:0] q, input logic [KVTOK_W-1:0] kv,
                              input logic sv, input logic kvp, input logic ls);
    int unsigned gap;
    reply_t r;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    item_handle_i  <= h;
    query_tokens_i <= q;
    kv_tokens_i    <= kv;
    save_kv_i      <= sv;
    kvp_request_i  <= kvp;
    list_start_i   <= ls;
    do @(posedge clk_i); while (!in_ready_o);
    arrange_step(c, h, q, kv, sv, kvp, ls, r);
    arranged_replies.insert(arranged_replies.size(), r);
    items_sent++;
  endtask

  // random operands that land in bucket b under the current threshold (bit 2 set if it is all ones)
  task automatic send_classified(input cmd_e c, input logic [BKT_W-1:0] b, input logic ls);
    logic [QTOK_W-1:0]  q;
    logic [KVTOK_W-1:0] kv;
    if (b[3]) begin
      q = QTOK_W'($urandom_range(0, 1));
    end else begin
      case ($urandom_range(0, 3))
        0:       q = 16'd2;
        1:       q = '1;
        default: q = QTOK_W'($urandom_range(2, 16'hFFFF));
      endcase
    end
    if (b[2] || thresh_m == '1) begin
      case ($urandom_range(0, 3))
        0:       kv = thresh_m;
        1:       kv = '0;
        default: kv = KVTOK_W'($urandom_range(0, thresh_m));
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       kv = thresh_m + KVTOK_W'(1);
        1:       kv = '1;
        default: kv = KVTOK_W'($urandom_range(thresh_m + 1, 20'hFFFFF));
      endcase
    end
    send_request(c, ITEM_W'($urandom_range(0, 16'hFFFF)), q, kv, !b[1], b[0], ls);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (arranged_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [THRESH_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thresh_m = val;
  endtask

  task automatic test_empty_read();
    send_request(CMD_READ, '1, '1, '1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_request(CMD_APPEND, 16'hFFFF, 16'd0, 20'd0, 1'b0, 1'b1, 1'b1);
    send_request(CMD_APPEND, 16'h0000, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0, 1'b0);
    send_request(CMD_APPEND, 16'hA5A5, 16'd1, thresh_m, 1'b1, 1'b1, 1'b0);
    send_request(CMD_APPEND, 16'h5A5A, 16'd2, thresh_m + 20'd1, 1'b0, 1'b0, 1'b1);
    send_request(CMD_APPEND, 16'h1234, 16'd2, thresh_m + 20'd1, 1'b0, 1'b1, 1'b0);
    send_request(CMD_APPEND, 16'h8001, 16'hFFFF, 20'd0, 1'b1, 1'b1, 1'b1);
    // six handles then a wrap to the start
    repeat (7) send_request(CMD_READ, '0, '0, '0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_checked_order();
    send_request(CMD_CHECKED, 16'h0C00, 16'd0, 20'd0, 1'b1, 1'b0, 1'b1);
    send_request(CMD_CHECKED, 16'h0D00, 16'd0, 20'd0, 1'b1, 1'b1, 1'b0);
    send_request(CMD_CHECKED, 16'h0D01, 16'd0, 20'd0, 1'b1, 1'b1, 1'b0);
    send_request(CMD_CHECKED, 16'h0200, 16'd2, thresh_m + 20'd1, 1'b0, 1'b0, 1'b0);
    send_request(CMD_CHECKED, 16'h0201, 16'd2, thresh_m + 20'd1, 1'b0, 1'b0, 1'b1);
    // plain append must not move the list position
    send_request(CMD_APPEND, 16'h0F00, 16'd0, 20'd0, 1'b0, 1'b1, 1'b0);
    send_request(CMD_CHECKED, 16'h0100, 16'd2, thresh_m + 20'd1, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_clear();
    send_request(CMD_CLEAR, '1, '1, '1, 1'b1, 1'b1, 1'b1);
    send_request(CMD_READ, '0, '0, '0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_overflow();
    logic [BKT_W-1:0] b, low;
    idle_en = 1'($urandom_range(0, 1));
    b = BKT_W'($urandom_range(5, 15));
    if (thresh_m == '1) b[2] = 1'b1;
    low = (thresh_m == '1) ? 4'd4 : 4'd0;
    send_classified(CMD_CLEAR, b, 1'b0);
    repeat (DEPTH + 2) begin
      send_classified($urandom_range(0, 1) ? CMD_APPEND : CMD_CHECKED, b, 1'b0);
    end
    // full bucket: dropped, yet the list position still moves to b
    send_classified(CMD_CHECKED, b, 1'b1);
    send_classified(CMD_CHECKED, low, 1'b0);
    repeat (DEPTH + 2) begin
      send_classified(CMD_READ, BKT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned stop_at, len, hot, k, i;
    logic [BKT_W-1:0] b;
    stop_at = items_sent + n;
    hot = $urandom_range(0, 15);
    while (items_sent < stop_at) begin
      idle_en = ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 99);
      if (k < 35) begin
        len = $urandom_range(1, 8);
        b = BKT_W'($urandom_range(0, 15));
        for (i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(0, 9) == 0) begin
            send_classified(CMD_CHECKED, BKT_W'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)));
          end else begin
            if (i != 0) b = BKT_W'($urandom_range(b, (b > 12) ? 15 : b + 3));
            send_classified(CMD_CHECKED, b, i == 0);
          end
        end
      end else if (k < 60) begin
        repeat ($urandom_range(1, 6)) begin
          send_classified(CMD_APPEND,
                          BKT_W'($urandom_range(0, 1) ? hot : $urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
        end
      end else if (k < 92) begin
        repeat ($urandom_range(1, 10)) begin
          send_classified(CMD_READ, BKT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
      end else if (k < 95) begin
        send_classified(CMD_CLEAR, BKT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        send_request(cmd_e'($urandom_range(0, 3)), ITEM_W'($urandom_range(0, 16'hFFFF)),
                     QTOK_W'($urandom_range(0, 16'hFFFF)),
                     KVTOK_W'($urandom_range(0, 20'hFFFFF)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : reply_monitor
    int unsigned hold;
    reply_t want;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (arranged_replies.size() == 0) begin
          report_mismatch("reply transfer with no command pending");
        end else begin
          want = arranged_replies.pop_front();
          check_field("data_valid", 32'(data_valid_o), 32'(want.data_valid));
          check_field("out_handle", 32'(out_handle_o), 32'(want.handle));
          check_field("split_index", 32'(split_index_o), 32'(want.split));
          check_field("last_in_split", 32'(last_in_split_o), 32'(want.last_split));
          check_field("last_overall", 32'(last_overall_o), 32'(want.last_all));
          check_field("order_error", 32'(order_error_o), 32'(want.order_err));
          check_field("overflow", 32'(overflow_o), 32'(want.ovf));
          check_field("empty_res", 32'(empty_res_o), 32'(want.empty));
        end
        hold = idle_en ? $urandom_range(0, 7) : 0;
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CMD_APPEND;
    item_handle_i  <= '0;
    query_tokens_i <= '0;
    kv_tokens_i    <= '0;
    save_kv_i      <= 1'b0;
    kvp_request_i  <= 1'b0;
    list_start_i   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_read();
    test_field_extremes();
    test_checked_order();
    test_clear();

    set_threshold('0);
    test_random(430);
    set_threshold('1);
    test_random(430);
    set_threshold(THRESH_W'($urandom_range(1, 20'hFFFFE)));
    test_overflow();
    test_random(430);
    set_threshold(20'd1);
    test_random(430);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
